FILE: rtl/core/pbia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbia_pkg: shared types and codes of the paired block ID allocator
// Payload structs of the three channels, command and status groups between
// controller and datapath, state, opcode, status and register index codes.
// ----------------------------------------------------------------------------
package pbia_pkg;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_LOOKUP   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_IN_BLOCK_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUB_BLOCK_WIDTH = 8'd1;

  localparam logic [5:0] IN_BLOCK_WIDTH_RESET  = 6'd24;
  localparam logic [4:0] SUB_BLOCK_WIDTH_RESET = 5'd8;

  typedef struct packed {
    opcode_t     opcode;
    logic [15:0] file_index;
    logic [31:0] part_index;
    logic [63:0] previous_id;
  } req_t;

  typedef struct packed {
    logic [63:0] alloc_id;
    status_t     status;
    logic [31:0] group_count;
  } rsp_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_t;

  typedef struct packed {
    logic [15:0] file;
    logic [31:0] part;
    logic [63:0] id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_read;
    logic calc;
    logic commit;
  } pbia_cmd_t;

  typedef struct packed {
    logic need_search;
    logic table_empty;
    logic scan_last;
    logic out_free;
  } pbia_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/pbia_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbia_chan_if: valid/ready channel
// Carries one payload item per handshake; source drives valid and payload,
// sink drives ready.
// ----------------------------------------------------------------------------
interface pbia_chan_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

FILE: rtl/core/pbia_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbia_ctrl: operation sequencer
// Accepts an item, walks the key table when needed, then computes and commits.
// ----------------------------------------------------------------------------
module pbia_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire pbia_pkg::pbia_stat_t stat,
  output pbia_pkg::pbia_cmd_t     cmd
);

  pbia_pkg::state_t state;
  pbia_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbia_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbia_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (stat.need_search && !stat.table_empty) begin
            state_next = pbia_pkg::ST_SCAN;
          end else begin
            state_next = pbia_pkg::ST_CALC;
          end
        end
      end
      pbia_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = pbia_pkg::ST_DRAIN;
        end
      end
      pbia_pkg::ST_DRAIN:  state_next = pbia_pkg::ST_CALC;
      pbia_pkg::ST_CALC:   state_next = pbia_pkg::ST_FINISH;
      pbia_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_next = pbia_pkg::ST_IDLE;
        end
      end
      default: state_next = pbia_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    case (state)
      pbia_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      pbia_pkg::ST_SCAN:   cmd.scan_read = 1'b1;
      pbia_pkg::ST_DRAIN:  cmd          = '0;
      pbia_pkg::ST_CALC:   cmd.calc     = 1'b1;
      pbia_pkg::ST_FINISH: cmd.commit   = stat.out_free;
      default:             cmd          = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/pbia_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbia_dpath: key table, ID arithmetic and result register
// Holds the configuration, group counter, fill count and key memory; runs the
// compare stage of the table walk and the two-step ID computation.
// ----------------------------------------------------------------------------
module pbia_dpath #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pbia_pkg::pbia_cmd_t cmd,
  output pbia_pkg::pbia_stat_t     stat,
  input  wire pbia_pkg::req_t      req_data,
  input  wire logic                cfg_valid,
  input  wire pbia_pkg::cfg_t      cfg_data,
  input  wire logic                rsp_ready,
  output logic                     rsp_valid,
  output pbia_pkg::rsp_t           rsp_data
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // configuration and persistent state
  logic [5:0]       in_w;
  logic [4:0]       sub_w;
  logic [31:0]      group_counter;
  logic [CNT_W-1:0] fill;

  pbia_pkg::entry_t mem [TABLE_ENTRIES];

  // item in flight
  pbia_pkg::req_t   item;
  logic             is_pair;
  logic [15:0]      key_file;
  logic [31:0]      key_part;

  // table walk
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld;
  pbia_pkg::entry_t rd_data;
  logic             a_hit;
  logic [63:0]      a_id;
  logic             own_hit;
  logic [IDX_W-1:0] own_idx;

  // ID computation
  logic [63:0]      t_id;
  logic [63:0]      addend;
  logic             fresh;

  logic [63:0]      req_mask64;
  logic             req_pair;
  logic [63:0]      mask64;
  logic [31:0]      mask32;
  logic [6:0]       sh;
  logic [63:0]      step;
  logic [63:0]      t_id_next;
  logic [63:0]      addend_next;
  logic             fresh_next;
  logic             full;
  logic             store_en;
  logic [IDX_W-1:0] waddr;
  logic [63:0]      id_sum;
  pbia_pkg::rsp_t   rsp_next;

  assign req_mask64 = (64'd1 << sub_w) - 64'd1;
  assign req_pair   = ((req_data.previous_id >> in_w) & req_mask64) == req_mask64;
  assign mask64     = req_mask64;
  assign mask32     = mask64[31:0];

  assign stat.need_search = (req_data.opcode == pbia_pkg::OP_LOOKUP) || req_pair;
  assign stat.table_empty = (fill == '0);
  assign stat.scan_last   = ((CNT_W'(addr) + CNT_W'(1)) == fill);
  assign stat.out_free    = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_w  <= pbia_pkg::IN_BLOCK_WIDTH_RESET;
      sub_w <= pbia_pkg::SUB_BLOCK_WIDTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_data.index == pbia_pkg::CFG_IN_BLOCK_WIDTH) begin
        in_w <= cfg_data.data[5:0];
      end else if (cfg_data.index == pbia_pkg::CFG_SUB_BLOCK_WIDTH) begin
        sub_w <= cfg_data.data[4:0];
      end
    end
  end

  // capture the item and the search key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= req_data;
      is_pair <= req_pair;
      if (req_data.opcode == pbia_pkg::OP_LOOKUP) begin
        key_file <= req_data.file_index;
        key_part <= req_data.part_index & ~mask32;
      end else begin
        key_file <= req_data.file_index ^ 16'd1;
        key_part <= req_data.part_index;
      end
    end
  end

  // walk address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.scan_read) begin
      addr <= addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_read) begin
      rd_data <= mem[addr];
      rd_addr <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[waddr] <= '{file: item.file_index, part: item.part_index, id: id_sum};
    end
  end

  // compare stage: keep the first match of each key
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_hit   <= 1'b0;
      own_hit <= 1'b0;
    end else if (rd_vld) begin
      if (!a_hit && rd_data.file == key_file && rd_data.part == key_part) begin
        a_hit <= 1'b1;
        a_id  <= rd_data.id;
      end
      if (!own_hit && rd_data.file == item.file_index &&
          rd_data.part == item.part_index) begin
        own_hit <= 1'b1;
        own_idx <= rd_addr;
      end
    end
  end

  // first step of the ID: base value and the term still to add
  assign sh   = 7'(in_w) + 7'(sub_w);
  assign step = 64'd1 << in_w;

  always_comb begin
    t_id_next   = '0;
    addend_next = '0;
    fresh_next  = 1'b0;
    case (item.opcode)
      pbia_pkg::OP_LOOKUP: begin
        t_id_next   = a_id;
        addend_next = {32'd0, item.part_index & mask32} << in_w;
      end
      pbia_pkg::OP_REGISTER: begin
        if (is_pair) begin
          if (a_hit) begin
            t_id_next = a_id ^ 64'd1;
          end else begin
            t_id_next   = (sh < 7'd64) ? ({32'd0, group_counter} << sh[5:0]) : 64'd0;
            addend_next = {63'd0, item.file_index[0]};
            fresh_next  = 1'b1;
          end
        end else begin
          t_id_next   = (item.previous_id + step) & ~(step - 64'd1);
          addend_next = {63'd0, item.file_index[0]};
        end
      end
      default: t_id_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      t_id   <= t_id_next;
      addend <= addend_next;
      fresh  <= fresh_next;
    end
  end

  // second step and commit
  assign id_sum   = t_id + addend;
  assign full     = (fill >= CNT_W'(TABLE_ENTRIES));
  assign store_en = cmd.commit && (item.opcode == pbia_pkg::OP_REGISTER) && is_pair &&
                    (own_hit || !full);
  assign waddr    = own_hit ? own_idx : fill[IDX_W-1:0];

  always_comb begin
    rsp_next.alloc_id    = id_sum;
    rsp_next.status      = pbia_pkg::STATUS_OK;
    rsp_next.group_count = group_counter + {31'd0, fresh};
    if (item.opcode == pbia_pkg::OP_LOOKUP) begin
      if (!a_hit) begin
        rsp_next.alloc_id = '1;
        rsp_next.status   = pbia_pkg::STATUS_NOT_FOUND;
      end
    end else if (is_pair && !own_hit && full) begin
      rsp_next.status = pbia_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_counter <= '0;
      fill          <= '0;
    end else if (cmd.commit) begin
      group_counter <= group_counter + {31'd0, fresh};
      if (store_en && !own_hit) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_data <= rsp_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill) || fill == $past(fill) + CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_read |-> (CNT_W'(addr) < fill))
    else $error("table walk read beyond filled entries");

  a_fresh_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && fresh |=> group_counter == $past(group_counter) + 32'd1)
    else $error("fresh group did not advance the counter");

  a_lookup_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && item.opcode == pbia_pkg::OP_LOOKUP && !a_hit |=>
      rsp_data.alloc_id == '1 && rsp_data.status == pbia_pkg::STATUS_NOT_FOUND)
    else $error("lookup miss without all-ones ID");

endmodule
`default_nettype wire

FILE: rtl/core/paired_block_id_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paired_block_id_allocator: block ID table for paired input files
// Registers (file, part) keys against 64-bit block IDs, reusing the partner
// file's ID where one exists, and looks IDs up by part number.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                          handshake
//   req      in   opcode, file_index, part_index, previous_id      valid/ready
//   rsp      out  alloc_id, status, group_count                    valid/ready
//   cfg      in   index (8 bits), data (6 bits)                    valid/ready
//
// Sequence: a register item whose sub-block field is not all ones, or any item
//   while the table is empty, goes straight to the ID computation; a search
//   item first walks the stored keys, fill being the number of stored keys.
//   The walk reads the key memory through its single read port, one entry a
//   cycle. A new item is accepted in the cycle after the previous commit.
// Reset: the fill count marks which entries are valid, so the table needs no
//   clearing pass. Registers return to 24 and 8.
// Stalls: a result waits in the output register while the next item is taken
//   and worked on; that item holds in its final step until the register frees.
// cfg is always ready; write it only while the block is idle.
//
module paired_block_id_allocator #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input wire logic clk,
  input wire logic rst,
  pbia_chan_if.sink   req,
  pbia_chan_if.source rsp,
  pbia_chan_if.sink   cfg
);

  pbia_pkg::pbia_cmd_t  cmd;
  pbia_pkg::pbia_stat_t stat;

  // configuration writes never stall
  assign cfg.ready = 1'b1;

  // sequencer: owns req ready and issues the datapath commands
  pbia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: table, arithmetic, result register
  pbia_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_data  (req.payload),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.payload),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_data  (rsp.payload)
  );

endmodule
`default_nettype wire
